FILE: rtl/eqbs_pkg.sv
// Shared types and constants of the equirectangular bilinear sampler.
`timescale 1ns / 1ps
`default_nettype none
package eqbs_pkg;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned CFG_W_W    = 11;
	localparam int unsigned CFG_H_W    = 10;
	localparam int unsigned PX_W       = 10;
	localparam int unsigned PY_W       = 9;
	localparam int unsigned CH_W       = 2;
	localparam int unsigned TEXEL_W    = 8;
	localparam int unsigned ANGLE_W    = 17;
	localparam int unsigned FRAC_W     = 8;
	localparam int unsigned RESULT_W   = 16;

	localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd1024;
	localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 10'd512;

	typedef struct packed {
		logic valid;
		logic op;
		logic ok;
	} ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/eqbs_ram.sv
// One byte-wide image copy with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module eqbs_ram #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned AW = 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/eqbs_coord.sv
// Input register, angle-to-position multiply, and wrap and clamp of the texel coordinates.
`timescale 1ns / 1ps
`default_nettype none
module eqbs_coord #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 512,
	parameter int unsigned CHANNELS = 4,
	parameter int unsigned WW = 11,
	parameter int unsigned HW = 10,
	parameter int unsigned XW = 10,
	parameter int unsigned YW = 9
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire logic                               in_take,
	input  wire logic                               op,
	input  wire logic [eqbs_pkg::PX_W-1:0]          pixel_x,
	input  wire logic [eqbs_pkg::PY_W-1:0]          pixel_y,
	input  wire logic [eqbs_pkg::CH_W-1:0]          channel,
	input  wire logic [eqbs_pkg::TEXEL_W-1:0]       texel_value,
	input  wire logic signed [eqbs_pkg::ANGLE_W-1:0] longitude,
	input  wire logic signed [eqbs_pkg::ANGLE_W-1:0] latitude,
	input  wire logic [WW-1:0]                      w_cur,
	input  wire logic [HW-1:0]                      h_cur,
	output eqbs_pkg::ctrl_t                         ctrl_s3,
	output logic [XW-1:0]                           x0_s3,
	output logic [XW-1:0]                           x1_s3,
	output logic [YW-1:0]                           y0_s3,
	output logic [YW-1:0]                           y1_s3,
	output logic [eqbs_pkg::FRAC_W-1:0]             fx_s3,
	output logic [eqbs_pkg::FRAC_W-1:0]             fy_s3,
	output logic [eqbs_pkg::CH_W-1:0]               ch_s3,
	output logic [eqbs_pkg::PX_W-1:0]               px_s3,
	output logic [eqbs_pkg::PY_W-1:0]               py_s3,
	output logic [eqbs_pkg::TEXEL_W-1:0]            tex_s3
);

	localparam int unsigned PW = WW + 19;
	localparam int unsigned PH = HW + 19;
	localparam int unsigned IXW = PW - 16;
	localparam int unsigned IYW = PH - 16;

	eqbs_pkg::ctrl_t ctrl_s1, ctrl_s2, ctrl_in;
	logic signed [eqbs_pkg::ANGLE_W-1:0] lon_s1, lat_s1;
	logic [WW-1:0] w_s1, w_s2, w_s3;
	logic [HW-1:0] h_s1, h_s2, h_s3;
	logic [eqbs_pkg::CH_W-1:0] ch_s1, ch_s2;
	logic [eqbs_pkg::PX_W-1:0] px_s1, px_s2;
	logic [eqbs_pkg::PY_W-1:0] py_s1, py_s2;
	logic [eqbs_pkg::TEXEL_W-1:0] tex_s1, tex_s2;
	logic signed [PW-1:0] posx_s2, lonx, wx, posx_n;
	logic signed [PH-1:0] posy_s2, latx, hx, posy_n;
	logic signed [IXW-1:0] ix, wsx, x0w, x1w;
	logic signed [IYW-1:0] iy, hsx, y0w, y1w;
	logic wr_ok, smp_ok;

	always_comb begin
		wr_ok = (32'(pixel_x) < MAX_WIDTH) && (32'(pixel_y) < MAX_HEIGHT)
			&& (32'(channel) < CHANNELS);
		smp_ok = 32'(channel) < CHANNELS;
		ctrl_in.valid = in_take;
		ctrl_in.op = op;
		ctrl_in.ok = (op == eqbs_pkg::OP_WRITE) ? wr_ok : smp_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_comb begin
		lonx = PW'(lon_s1);
		wx = PW'({1'b0, w_s1});
		posx_n = lonx * wx + ((wx - PW'(1)) <<< 15);
		latx = PH'(lat_s1);
		hx = PH'({1'b0, h_s1});
		posy_n = ((hx - PH'(1)) <<< 15) - latx * hx;
	end

	always_comb begin
		ix = posx_s2[PW-1:16];
		iy = posy_s2[PH-1:16];
		wsx = IXW'({1'b0, w_s2});
		hsx = IYW'({1'b0, h_s2});
		if (ix < 0) begin
			x0w = ix + wsx;
		end else if (ix >= wsx) begin
			x0w = ix - wsx;
		end else begin
			x0w = ix;
		end
		x1w = (x0w + IXW'(1) == wsx) ? '0 : x0w + IXW'(1);
		if (iy < 0) begin
			y0w = '0;
			y1w = '0;
		end else if (iy >= hsx - IYW'(1)) begin
			y0w = hsx - IYW'(1);
			y1w = hsx - IYW'(1);
		end else begin
			y0w = iy;
			y1w = iy + IYW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lon_s1 <= longitude;
			lat_s1 <= latitude;
			w_s1 <= w_cur;
			h_s1 <= h_cur;
			ch_s1 <= channel;
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
			tex_s1 <= texel_value;
			posx_s2 <= posx_n;
			posy_s2 <= posy_n;
			w_s2 <= w_s1;
			h_s2 <= h_s1;
			ch_s2 <= ch_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			tex_s2 <= tex_s1;
			x0_s3 <= XW'(x0w);
			x1_s3 <= XW'(x1w);
			y0_s3 <= YW'(y0w);
			y1_s3 <= YW'(y1w);
			fx_s3 <= posx_s2[15:8];
			fy_s3 <= posy_s2[15:8];
			w_s3 <= w_s2;
			h_s3 <= h_s2;
			ch_s3 <= ch_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			tex_s3 <= tex_s2;
		end
	end

`ifndef NO_ASSERTIONS
	a_x0_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s3.valid && ctrl_s3.op == eqbs_pkg::OP_SAMPLE |-> 32'(x0_s3) < 32'(w_s3))
		else $error("column x0 outside the image");
	a_x1_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s3.valid && ctrl_s3.op == eqbs_pkg::OP_SAMPLE |-> 32'(x1_s3) < 32'(w_s3))
		else $error("column x1 outside the image");
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s3.valid && ctrl_s3.op == eqbs_pkg::OP_SAMPLE
		|-> y0_s3 <= y1_s3 && 32'(y1_s3) < 32'(h_s3))
		else $error("rows out of order or outside the image");
`endif

endmodule
`default_nettype wire

FILE: rtl/eqbs_blend.sv
// Two-stage bilinear blend of the four neighbor texels.
`timescale 1ns / 1ps
`default_nettype none
module eqbs_blend (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            adv,
	input  wire eqbs_pkg::ctrl_t                 ctrl_s4,
	input  wire logic [eqbs_pkg::FRAC_W-1:0]     fx_s4,
	input  wire logic [eqbs_pkg::FRAC_W-1:0]     fy_s4,
	input  wire logic [7:0]                      tl_s4,
	input  wire logic [7:0]                      tr_s4,
	input  wire logic [7:0]                      bl_s4,
	input  wire logic [7:0]                      br_s4,
	output logic                                 valid_s6,
	output logic [eqbs_pkg::RESULT_W-1:0]        value_s6
);

	logic valid_s5, ok_s5;
	logic [16:0] top_s5, bot_s5;
	logic [8:0] gx, gxi, gy, gyi;
	logic [8:0] fy_s5;
	logic [25:0] acc;

	always_comb begin
		gx = {1'b0, fx_s4};
		gxi = 9'd256 - gx;
		gy = fy_s5;
		gyi = 9'd256 - gy;
		acc = 26'(top_s5) * 26'(gyi) + 26'(bot_s5) * 26'(gy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= ctrl_s4.valid && ctrl_s4.op == eqbs_pkg::OP_SAMPLE;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s5 <= ctrl_s4.ok;
			fy_s5 <= {1'b0, fy_s4};
			top_s5 <= 17'(tl_s4) * 17'(gxi) + 17'(tr_s4) * 17'(gx);
			bot_s5 <= 17'(bl_s4) * 17'(gxi) + 17'(br_s4) * 17'(gx);
			value_s6 <= ok_s5 ? acc[23:8] : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_blend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> top_s5 <= 17'd65280 && bot_s5 <= 17'd65280)
		else $error("row blend above the byte range");
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s5 && !ok_s5 |=> value_s6 == '0)
		else $error("missing channel gave a nonzero result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(value_s6) && $stable(valid_s6))
		else $error("output stage changed while held");
`endif

endmodule
`default_nettype wire

FILE: rtl/equirect_bilinear_sampler_top.sv
// Top level of the equirectangular bilinear sampler.
// Usage: the input channel (in_valid, in_stall) carries one item per accepted
// cycle. An item with op 0 writes texel_value to the texel at pixel_x, pixel_y,
// channel and gives no result. An item with op 1 samples the image at longitude
// and latitude in that channel and gives one result on the output channel
// (out_valid, out_stall) as sample_value, 8.8 fixed point in byte units.
// Every texel that a sample touches must have been written before.
// The configuration port (cfg_we, cfg_index, cfg_data) sets image_width
// (index 0) and image_height (index 1); write it only while no item is in flight.
// out_valid is the last blend register. One item is accepted every cycle unless
// stalled; the image is held in four copies so that four texels are read in the
// memory stage each cycle. Results come out in input order. Reset clears all
// valid bits and sets the size to 1024 by 512; image contents are undefined until
// written. While the receiver stalls a held result, the whole pipeline holds and
// in_stall is raised, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module equirect_bilinear_sampler_top #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 512,
	parameter int unsigned CHANNELS = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_index,
	input  wire logic [eqbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                op,
	input  wire logic [eqbs_pkg::PX_W-1:0]           pixel_x,
	input  wire logic [eqbs_pkg::PY_W-1:0]           pixel_y,
	input  wire logic [eqbs_pkg::CH_W-1:0]           channel,
	input  wire logic [eqbs_pkg::TEXEL_W-1:0]        texel_value,
	input  wire logic signed [eqbs_pkg::ANGLE_W-1:0] longitude,
	input  wire logic signed [eqbs_pkg::ANGLE_W-1:0] latitude,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [eqbs_pkg::RESULT_W-1:0]            sample_value
);

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned XW = $clog2(MAX_WIDTH);
	localparam int unsigned YW = $clog2(MAX_HEIGHT);
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
	localparam int unsigned AW = $clog2(DEPTH);

	logic [eqbs_pkg::CFG_W_W-1:0] width_q;
	logic [eqbs_pkg::CFG_H_W-1:0] height_q;
	logic [WW-1:0] w_cur;
	logic [HW-1:0] h_cur;
	logic adv, valid_s6, wr_en;
	eqbs_pkg::ctrl_t ctrl_s3, ctrl_s4;
	logic [XW-1:0] x0_s3, x1_s3;
	logic [YW-1:0] y0_s3, y1_s3;
	logic [eqbs_pkg::FRAC_W-1:0] fx_s3, fy_s3, fx_s4, fy_s4;
	logic [eqbs_pkg::CH_W-1:0] ch_s3;
	logic [eqbs_pkg::PX_W-1:0] px_s3;
	logic [eqbs_pkg::PY_W-1:0] py_s3;
	logic [eqbs_pkg::TEXEL_W-1:0] tex_s3;
	logic [AW-1:0] waddr, a_tl, a_tr, a_bl, a_br;
	logic [7:0] tl_s4, tr_s4, bl_s4, br_s4;

	function automatic logic [AW-1:0] addr_of(input logic [31:0] y, input logic [31:0] x,
		input logic [31:0] c);
		logic [31:0] lin;
		lin = (y * MAX_WIDTH + x) * CHANNELS + c;
		return lin[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= eqbs_pkg::WIDTH_RESET;
			height_q <= eqbs_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				eqbs_pkg::CFG_WIDTH: width_q <= cfg_data[eqbs_pkg::CFG_W_W-1:0];
				eqbs_pkg::CFG_HEIGHT: height_q <= cfg_data[eqbs_pkg::CFG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_cur = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_cur = WW'(MAX_WIDTH);
		end else begin
			w_cur = WW'(width_q);
		end
		if (height_q == '0) begin
			h_cur = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_cur = HW'(MAX_HEIGHT);
		end else begin
			h_cur = HW'(height_q);
		end
	end

	assign adv = !valid_s6 || !out_stall;
	assign in_stall = !adv;
	assign out_valid = valid_s6;

	eqbs_coord #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CHANNELS(CHANNELS),
		.WW(WW),
		.HW(HW),
		.XW(XW),
		.YW(YW)
	) u_coord (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_take(in_valid),
		.op(op),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.channel(channel),
		.texel_value(texel_value),
		.longitude(longitude),
		.latitude(latitude),
		.w_cur(w_cur),
		.h_cur(h_cur),
		.ctrl_s3(ctrl_s3),
		.x0_s3(x0_s3),
		.x1_s3(x1_s3),
		.y0_s3(y0_s3),
		.y1_s3(y1_s3),
		.fx_s3(fx_s3),
		.fy_s3(fy_s3),
		.ch_s3(ch_s3),
		.px_s3(px_s3),
		.py_s3(py_s3),
		.tex_s3(tex_s3)
	);

	always_comb begin
		wr_en = adv && ctrl_s3.valid && ctrl_s3.op == eqbs_pkg::OP_WRITE && ctrl_s3.ok;
		waddr = addr_of(32'(py_s3), 32'(px_s3), 32'(ch_s3));
		a_tl = addr_of(32'(y0_s3), 32'(x0_s3), 32'(ch_s3));
		a_tr = addr_of(32'(y0_s3), 32'(x1_s3), 32'(ch_s3));
		a_bl = addr_of(32'(y1_s3), 32'(x0_s3), 32'(ch_s3));
		a_br = addr_of(32'(y1_s3), 32'(x1_s3), 32'(ch_s3));
	end

	eqbs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_tl (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(tex_s3),
		.re(adv), .raddr(a_tl), .rdata(tl_s4)
	);
	eqbs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_tr (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(tex_s3),
		.re(adv), .raddr(a_tr), .rdata(tr_s4)
	);
	eqbs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_bl (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(tex_s3),
		.re(adv), .raddr(a_bl), .rdata(bl_s4)
	);
	eqbs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_br (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(tex_s3),
		.re(adv), .raddr(a_br), .rdata(br_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4 <= '0;
		end else if (adv) begin
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
		end
	end

	eqbs_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.ctrl_s4(ctrl_s4),
		.fx_s4(fx_s4),
		.fy_s4(fy_s4),
		.tl_s4(tl_s4),
		.tr_s4(tr_s4),
		.bl_s4(bl_s4),
		.br_s4(br_s4),
		.valid_s6(valid_s6),
		.value_s6(sample_value)
	);

`ifndef NO_ASSERTIONS
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctrl_s4))
		else $error("memory stage moved while the pipeline was held");
	a_no_write_held: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !in_stall)
		else $error("texel written while the pipeline was held");
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		w_cur != '0 && h_cur != '0 && 32'(w_cur) <= MAX_WIDTH && 32'(h_cur) <= MAX_HEIGHT)
		else $error("image size outside the store");
`endif

endmodule
`default_nettype wire
